/* rtl/qcr_pkg.sv */
// Shared types, constants and tables for the QPSK Costas carrier recovery loop.
`timescale 1ns / 1ps
package qcr_pkg;

   // CORDIC micro-rotations, capped by the arctangent table
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam int STEP_W       = $clog2(ATAN_LEN);

   // datapath: sample bits, guard bits, rotation and angle widths
   localparam int SMP_W   = 16;
   localparam int GUARD   = 16;
   localparam int DW      = 36;
   localparam int ZW      = 34;
   localparam int ATAN_W  = 30;

   // shared multiplier, split operand for the gain compensation
   localparam int LO_W    = 18;
   localparam int MUL_AW  = DW - LO_W + 1;
   localparam int MUL_BW  = 32;
   localparam int MUL_PW  = MUL_AW + MUL_BW;
   localparam int ACC_W   = 67;
   localparam int COMP_SHIFT = 46;
   localparam int COMP_W  = ACC_W - COMP_SHIFT;
   localparam logic [ATAN_W-1:0] INV_GAIN = 30'd652032874;
   localparam int GAIN_SHIFT = 13;
   localparam int GAIN_W  = 31;

   // detector error, Q2.13
   localparam int ERR_W = 15;
   localparam int ERR_RAW_W = 18;
   localparam logic signed [ERR_W-1:0] ERR_ONE = 15'sd8192;

   // configuration register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INT_GAIN  = 4'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROT,
      ST_XLO,
      ST_XHI,
      ST_YLO,
      ST_YHI,
      ST_ERR,
      ST_FREQ,
      ST_PHASE,
      ST_DONE
   } state_type;

   // arctangent of 2^-i in 2^-32 turn
   function automatic logic [ATAN_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
      logic [ATAN_W-1:0] r;
      unique case (idx)
         5'd0:    r = 30'd536870912;
         5'd1:    r = 30'd316933406;
         5'd2:    r = 30'd167458907;
         5'd3:    r = 30'd85004756;
         5'd4:    r = 30'd42667331;
         5'd5:    r = 30'd21354465;
         5'd6:    r = 30'd10679838;
         5'd7:    r = 30'd5340245;
         5'd8:    r = 30'd2670163;
         5'd9:    r = 30'd1335087;
         5'd10:   r = 30'd667544;
         5'd11:   r = 30'd333772;
         5'd12:   r = 30'd166886;
         5'd13:   r = 30'd83443;
         5'd14:   r = 30'd41722;
         5'd15:   r = 30'd20861;
         5'd16:   r = 30'd10430;
         5'd17:   r = 30'd5215;
         5'd18:   r = 30'd2608;
         5'd19:   r = 30'd1304;
         5'd20:   r = 30'd652;
         5'd21:   r = 30'd326;
         5'd22:   r = 30'd163;
         5'd23:   r = 30'd81;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/qpsk_costas_carrier_recovery.sv */
// QPSK Costas loop: iterative CORDIC derotation, sign detector and PI NCO update.
// A new sample is taken only in the idle state, once the previous result is published.
// The CORDIC stage runs one micro-rotation per cycle and one shared 19x32 multiplier
// serves compensation and gains.
// Reset (synchronous, active high) clears phase, frequency, both gains and the result slot.
`timescale 1ns / 1ps
module qpsk_costas_carrier_recovery (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [15:0]                  req_in_i,
   input  logic signed [15:0]                  req_in_q,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [15:0]                  rsp_out_i,
   output logic signed [15:0]                  rsp_out_q,
   output logic signed [14:0]                  rsp_phase_error,
   output logic signed [31:0]                  rsp_freq_estimate,
   output logic signed [15:0]                  rsp_phase_estimate,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qcr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                         csr_data
);
   import qcr_pkg::*;

   state_type                  state_ff, state_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic signed [DW-1:0]       x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]       z_ff, z_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [SMP_W-1:0]    ri_ff, ri_in, rq_ff, rq_in;
   logic signed [ERR_W-1:0]    e_ff, e_in;
   logic [31:0]                phase_acc_ff, phase_acc_in;
   logic signed [31:0]         freq_acc_ff, freq_acc_in;
   logic [GAIN_W-1:0]          prop_gain_ff, int_gain_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       publish;
   logic signed [SMP_W-1:0]    out_i_ff, out_q_ff, phase_est_ff;
   logic signed [ERR_W-1:0]    err_out_ff;
   logic signed [31:0]         freq_out_ff;

   // shared multiplier
   logic signed [MUL_AW-1:0]   mul_a;
   logic signed [MUL_BW-1:0]   mul_b;
   logic signed [MUL_PW-1:0]   mul_p;
   logic signed [ACC_W-1:0]    mul_ext;

   // fold and load
   logic [31:0]                zu, zf;
   logic                       flip;
   logic signed [DW-1:0]       xs, ys;

   // CORDIC step
   logic signed [DW-1:0]       dx, dy;
   logic signed [ZW-1:0]       at;

   // compensation result, detector, loop update
   logic signed [COMP_W-1:0]   comp_raw;
   logic signed [SMP_W-1:0]    comp_sat;
   logic signed [ERR_RAW_W-1:0] ri_x, rq_x, t1, t2, e_raw;
   logic signed [33:0]         fsum;

   localparam logic signed [ACC_W-1:0] COMP_RND = ACC_W'(1) <<< (COMP_SHIFT - 1);

   function automatic logic signed [SMP_W-1:0] sat16(input logic signed [COMP_W-1:0] v);
      logic signed [SMP_W-1:0] r;
      if (v > COMP_W'(32767)) begin
         r = 16'sh7FFF;
      end else if (v < -COMP_W'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[SMP_W-1:0];
      end
      return r;
   endfunction

   assign mul_p   = mul_a * mul_b;
   assign mul_ext = {{(ACC_W-MUL_PW){mul_p[MUL_PW-1]}}, mul_p};

   assign comp_raw = acc_ff[ACC_W-1:COMP_SHIFT];
   assign comp_sat = sat16(comp_raw);

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign publish   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // angle fold: bring -phase into [-1/4, 1/4) turn
   assign zu   = 32'd0 - phase_acc_ff;
   assign flip = (zu[31:30] == 2'b01) || (zu[31:30] == 2'b10);
   assign zf   = flip ? (zu + 32'h8000_0000) : zu;
   assign xs   = {{(DW-SMP_W-GUARD){req_in_i[15]}}, req_in_i, {GUARD{1'b0}}};
   assign ys   = {{(DW-SMP_W-GUARD){req_in_q[15]}}, req_in_q, {GUARD{1'b0}}};

   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;
   assign at = {{(ZW-ATAN_W){1'b0}}, atan_turn(step_ff)};

   // sign detector on the compensated parts
   assign ri_x  = {{(ERR_RAW_W-SMP_W){ri_ff[SMP_W-1]}}, ri_ff};
   assign rq_x  = {{(ERR_RAW_W-SMP_W){comp_sat[SMP_W-1]}}, comp_sat};
   assign t1    = ri_ff[SMP_W-1] ? -rq_x : rq_x;
   assign t2    = comp_sat[SMP_W-1] ? -ri_x : ri_x;
   assign e_raw = t1 - t2;

   assign fsum = {{2{freq_acc_ff[31]}}, freq_acc_ff} + mul_p[GAIN_SHIFT+33:GAIN_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         phase_acc_ff <= '0;
         freq_acc_ff  <= '0;
         prop_gain_ff <= '0;
         int_gain_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_acc_ff <= phase_acc_in;
         freq_acc_ff  <= freq_acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_PROP_GAIN) begin
               prop_gain_ff <= csr_data[GAIN_W-1:0];
            end else if (csr_index == REG_INT_GAIN) begin
               int_gain_ff <= csr_data[GAIN_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      acc_ff <= acc_in;
      ri_ff  <= ri_in;
      rq_ff  <= rq_in;
      e_ff   <= e_in;
      if (publish) begin
         out_i_ff     <= ri_ff;
         out_q_ff     <= rq_ff;
         err_out_ff   <= e_ff;
         freq_out_ff  <= freq_acc_ff;
         phase_est_ff <= phase_acc_ff[31:16];
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      acc_in       = acc_ff;
      ri_in        = ri_ff;
      rq_in        = rq_ff;
      e_in         = e_ff;
      phase_acc_in = phase_acc_ff;
      freq_acc_in  = freq_acc_ff;
      mul_a        = '0;
      mul_b        = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = flip ? -xs : xs;
               y_in     = flip ? -ys : ys;
               z_in     = {{(ZW-32){zf[31]}}, zf};
               step_in  = '0;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            // rotate toward zero residual angle
            if (!z_ff[ZW-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + at;
            end
            if (step_ff == STEP_W'(CORDIC_ITERS - 1)) begin
               state_in = ST_XLO;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_XLO: begin
            mul_a    = {1'b0, x_ff[LO_W-1:0]};
            mul_b    = {{(MUL_BW-ATAN_W){1'b0}}, INV_GAIN};
            acc_in   = mul_ext + COMP_RND;
            state_in = ST_XHI;
         end
         ST_XHI: begin
            mul_a    = {x_ff[DW-1], x_ff[DW-1:LO_W]};
            mul_b    = {{(MUL_BW-ATAN_W){1'b0}}, INV_GAIN};
            acc_in   = acc_ff + (mul_ext <<< LO_W);
            state_in = ST_YLO;
         end
         ST_YLO: begin
            ri_in    = comp_sat;
            mul_a    = {1'b0, y_ff[LO_W-1:0]};
            mul_b    = {{(MUL_BW-ATAN_W){1'b0}}, INV_GAIN};
            acc_in   = mul_ext + COMP_RND;
            state_in = ST_YHI;
         end
         ST_YHI: begin
            mul_a    = {y_ff[DW-1], y_ff[DW-1:LO_W]};
            mul_b    = {{(MUL_BW-ATAN_W){1'b0}}, INV_GAIN};
            acc_in   = acc_ff + (mul_ext <<< LO_W);
            state_in = ST_ERR;
         end
         ST_ERR: begin
            rq_in = comp_sat;
            if (e_raw > ERR_RAW_W'(ERR_ONE)) begin
               e_in = ERR_ONE;
            end else if (e_raw < -ERR_RAW_W'(ERR_ONE)) begin
               e_in = -ERR_ONE;
            end else begin
               e_in = e_raw[ERR_W-1:0];
            end
            state_in = ST_FREQ;
         end
         ST_FREQ: begin
            mul_a = {{(MUL_AW-ERR_W){e_ff[ERR_W-1]}}, e_ff};
            mul_b = {1'b0, int_gain_ff};
            // saturate the frequency accumulator
            if (fsum > 34'sh0_7FFF_FFFF) begin
               freq_acc_in = 32'sh7FFF_FFFF;
            end else if (fsum < -34'sh0_8000_0000) begin
               freq_acc_in = 32'sh8000_0000;
            end else begin
               freq_acc_in = fsum[31:0];
            end
            state_in = ST_PHASE;
         end
         ST_PHASE: begin
            mul_a        = {{(MUL_AW-ERR_W){e_ff[ERR_W-1]}}, e_ff};
            mul_b        = {1'b0, prop_gain_ff};
            // phase wraps modulo one turn
            phase_acc_in = phase_acc_ff + freq_acc_ff + mul_p[GAIN_SHIFT+31:GAIN_SHIFT];
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result slot frees up
            if (publish) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_i          = out_i_ff;
   assign rsp_out_q          = out_q_ff;
   assign rsp_phase_error    = err_out_ff;
   assign rsp_freq_estimate  = freq_out_ff;
   assign rsp_phase_estimate = phase_est_ff;

endmodule

/* rtl/qcr_checker.sv */
// Port-level checks for the QPSK Costas carrier recovery loop, bound to the top level.
`timescale 1ns / 1ps
module qcr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [15:0]                  rsp_out_i,
   input logic signed [15:0]                  rsp_out_q,
   input logic signed [14:0]                  rsp_phase_error,
   input logic signed [31:0]                  rsp_freq_estimate,
   input logic signed [15:0]                  rsp_phase_estimate
);
   import qcr_pkg::*;

   // reset empties the result slot
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // one sample at a time: busy right after a word is taken
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready right after a word was taken");

   // detector error stays clamped to plus or minus one
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_phase_error <= ERR_ONE) && (rsp_phase_error >= -ERR_ONE)))
      else $error("phase error outside clamp range");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_i) && $stable(rsp_out_q)
         && $stable(rsp_phase_error) && $stable(rsp_freq_estimate)
         && $stable(rsp_phase_estimate)))
      else $error("stalled result word changed");

endmodule

bind qpsk_costas_carrier_recovery qcr_checker u_qcr_checker (.*);
